[rtl/core/quad_stack_with_centre_and_crossing_defines.svh]
// Assertion macros shared by the checker of the quadrilateral stack.
// No dependencies; included by files that hold concurrent assertions.
`ifndef QUAD_STACK_WITH_CENTRE_AND_CROSSING_DEFINES_SVH
`define QUAD_STACK_WITH_CENTRE_AND_CROSSING_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define QSC_CHECK(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define QSC_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/qsc_pkg.sv]
// Shared types, codes and field layout of the quadrilateral stack block.
// No dependencies; imported by every module of the block except qsc_ram.
package qsc_pkg;

   // Default parameter values.
   localparam int DEF_STACK_DEPTH = 64;
   localparam int DEF_COORD_BITS  = 12;

   // Channel widths.
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 112;
   localparam int CSR_DATA_W = 13;
   localparam int IN_COORD_W = 16;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 7;
   localparam int CENTRE_W   = 12;
   localparam int CROSS_W    = 40;

   // Bit positions in the request data.
   localparam int OFS_INDEX = 128;
   localparam int OFS_PAIR  = 134;

   typedef enum logic [1:0] {
      MODE_PUSH  = 2'd0,
      MODE_POP   = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Line pair selectors that swap P3 with another corner.
   localparam logic [1:0] PAIR_SWAP_P1 = 2'd1;
   localparam logic [1:0] PAIR_SWAP_P2 = 2'd2;

   // Configuration register indexes.
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   // Product steps of the crossing computation.
   localparam logic [2:0] STEP_AD   = 3'd0;
   localparam logic [2:0] STEP_CB   = 3'd1;
   localparam logic [2:0] STEP_DE   = 3'd2;
   localparam logic [2:0] STEP_CF   = 3'd3;
   localparam logic [2:0] STEP_NUMA = 3'd4;
   localparam logic [2:0] STEP_NUMB = 3'd5;

endpackage

[rtl/core/qsc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the stored quadrilaterals.
module qsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/qsc_mul.sv]
// Bit-serial signed multiplier: one multiplier bit is consumed per cycle.
// Uses qsc_pkg for house conventions only.
module qsc_mul #(
   parameter int A_W = 27,
   parameter int B_W = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [A_W-1:0] op_a,
   input  logic signed [B_W-1:0] op_b,
   output logic                  busy,
   output logic                  done,
   output logic signed [A_W+B_W-1:0] product
);
   import qsc_pkg::*;

   localparam int PW  = A_W + B_W;
   localparam int CTW = (B_W > 1) ? $clog2(B_W) : 1;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CTW-1:0]  cnt_ff, cnt_in;
   logic [PW-1:0]   acc_ff, acc_in;
   logic [A_W-1:0]  mcand_ff, mcand_in;
   logic            neg_ff, neg_in;
   logic [PW-1:0]   prod_ff, prod_in;
   logic [A_W-1:0]  a_mag;
   logic [B_W-1:0]  b_mag;
   logic [A_W:0]    upper;
   logic [PW-1:0]   acc_step;

   // Magnitudes of the operands; the sign is applied at the end.
   assign a_mag = op_a[A_W-1] ? (~op_a + 1'b1) : op_a;
   assign b_mag = op_b[B_W-1] ? (~op_b + 1'b1) : op_b;

   // One shift-and-add step on the low multiplier bit.
   assign upper    = {1'b0, acc_ff[PW-1:B_W]} + (acc_ff[0] ? {1'b0, mcand_ff} : '0);
   assign acc_step = {upper, acc_ff[B_W-1:1]};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      if (busy_ff) begin
         acc_in = acc_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CTW'(B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            prod_in = neg_ff ? (~acc_step + 1'b1) : acc_step;
         end
      end else if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         acc_in   = {{A_W{1'b0}}, b_mag};
         mcand_in = a_mag;
         neg_in   = op_a[A_W-1] ^ op_b[B_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = prod_ff;

endmodule

[rtl/core/qsc_div.sv]
// Bit-serial restoring divider, signed, quotient truncated toward zero.
// Uses qsc_pkg for house conventions only; one quotient bit per cycle.
module qsc_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 27
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] dividend,
   input  logic signed [DEN_W-1:0] divisor,
   output logic                    busy,
   output logic                    done,
   output logic signed [NUM_W:0]   quotient
);
   import qsc_pkg::*;

   localparam int CTW = $clog2(NUM_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CTW-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  dmag_ff, dmag_in;
   logic              neg_ff, neg_in;
   logic [NUM_W:0]    res_ff, res_in;
   logic [DEN_W:0]    trial;
   logic              fits;
   logic [DEN_W:0]    diff;
   logic [NUM_W-1:0]  quo_step;

   // Bring down the next dividend bit and try a subtraction.
   assign trial    = {rem_ff, quo_ff[NUM_W-1]};
   assign diff     = trial - {1'b0, dmag_ff};
   assign fits     = trial >= {1'b0, dmag_ff};
   assign quo_step = {quo_ff[NUM_W-2:0], fits};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = quo_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CTW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? (~{1'b0, quo_step} + 1'b1) : {1'b0, quo_step};
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
         dmag_in = divisor[DEN_W-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[NUM_W-1] ^ divisor[DEN_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

[rtl/core/quad_stack_with_centre_and_crossing.sv]
// Quadrilateral stack with integer centroid and crossing of two corner lines.
// Depends on qsc_pkg, qsc_ram, qsc_mul and qsc_div.
//
// Push, pop and clear requests go from idle to the output state; their response
// is loaded into the output register once it is free, after which the block
// takes the next request. A query reads the stored quad from the stack RAM and
// then runs six products through one bit-serial multiplier and two divisions
// through one bit-serial divider. Parallel lines skip the last two products
// and both divisions. One request is in work at a time; a new request is
// accepted while the previous response still waits in the output register,
// and a finished request waits for that register to empty. Corners are
// clamped to the frame when pushed; the stack needs no clearing after reset.
module quad_stack_with_centre_and_crossing #(
   parameter int STACK_DEPTH = qsc_pkg::DEF_STACK_DEPTH,
   parameter int COORD_BITS  = qsc_pkg::DEF_COORD_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, entry_index, line_pair
   input  logic [qsc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode
   input  logic [1:0]                       req_tuser,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // stack_count, centre_x, centre_y, cross_x, cross_y, lines_parallel
   output logic [qsc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [1:0]                       rsp_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [qsc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import qsc_pkg::*;

   localparam int CW     = COORD_BITS;
   localparam int DW     = CW + 1;
   localparam int PW     = 2 * DW;
   localparam int EW     = PW + 1;
   localparam int NW     = EW + DW;
   localparam int QW     = NW + 1;
   localparam int RW     = (QW + 1 > CROSS_W) ? QW + 1 : CROSS_W;
   localparam int AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNTW   = $clog2(STACK_DEPTH + 1);
   localparam int IXW    = (CNTW > INDEX_W) ? CNTW : INDEX_W;
   localparam int SZW    = (CW + 1 > CSR_DATA_W) ? CW + 1 : CSR_DATA_W;
   localparam int WORD_W = 8 * CW;

   // Clamp a signed input coordinate to 0..hi.
   function automatic logic [CW-1:0] clamp_coord(input logic [IN_COORD_W-1:0] v,
                                                  input logic [CW-1:0] hi);
      logic [CW-1:0] r;
      if (v[IN_COORD_W-1]) begin
         r = '0;
      end else if (v > IN_COORD_W'(hi)) begin
         r = hi;
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

   // Largest coordinate allowed by a frame size.
   function automatic logic [CW-1:0] limit_of(input logic [CSR_DATA_W-1:0] size);
      logic [SZW-1:0] sz;
      logic [SZW-1:0] cap;
      sz  = SZW'(size);
      cap = SZW'(2 ** CW);
      if (sz > cap) begin
         sz = cap;
      end
      return (sz == '0) ? '0 : CW'(sz - 1'b1);
   endfunction

   state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] frame_width_ff, frame_height_ff;
   logic [CNTW-1:0]       count_ff;
   logic [2:0]            step_ff;
   logic [1:0]            pair_ff;
   logic signed [DW-1:0]  a_ff, b_ff, c_ff, d_ff, e_ff, f_ff;
   logic [CW-1:0]         x3_ff, y3_ff;
   logic signed [NW-1:0]  t0_ff;
   logic signed [EW-1:0]  den_ff, num_ff;
   status_type            res_status_ff;
   logic [CENTRE_W-1:0]   res_cx_ff, res_cy_ff;
   logic [CROSS_W-1:0]    res_kx_ff, res_ky_ff;
   logic                  res_par_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [1:0]            rsp_user_ff;

   logic                  req_fire, rsp_load;
   mode_type              mode;
   logic                  stack_empty, stack_full;
   logic [CW-1:0]         lim_x, lim_y;
   logic [WORD_W-1:0]     wr_word, rd_word;
   logic                  wr_en;
   logic [IXW-1:0]        idx_ext, top_ext, idx_sel;
   logic [CW-1:0]         qx [4];
   logic [CW-1:0]         qy [4];
   logic [CW-1:0]         sx0, sx1, sx2, sx3, sy0, sy1, sy2, sy3;
   logic [CW+1:0]         sum_x, sum_y;
   logic                  mul_start, mul_busy, mul_done;
   logic signed [EW-1:0]  mul_a;
   logic signed [DW-1:0]  mul_b;
   logic signed [NW-1:0]  mul_prod;
   logic                  div_start, div_busy, div_done;
   logic signed [QW-1:0]  div_quot;
   logic [RW-1:0]         cross_sum;

   assign req_fire    = req_tvalid && req_tready;
   assign mode        = mode_type'(req_tuser);
   assign stack_empty = (count_ff == '0);
   assign stack_full  = (count_ff == CNTW'(STACK_DEPTH));
   assign csr_ready   = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default:          frame_width_ff  <= frame_width_ff;
         endcase
      end
   end

   // Clamp the pushed corners to the frame and pack them as one RAM word.
   assign lim_x = limit_of(frame_width_ff);
   assign lim_y = limit_of(frame_height_ff);

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         wr_word[j*CW +: CW] =
            clamp_coord(req_tdata[(2*j)*IN_COORD_W +: IN_COORD_W], lim_x);
         wr_word[(4+j)*CW +: CW] =
            clamp_coord(req_tdata[(2*j+1)*IN_COORD_W +: IN_COORD_W], lim_y);
      end
   end

   assign wr_en = req_fire && (mode == MODE_PUSH) && !stack_full;

   // Query index clamped to the top entry.
   assign idx_ext = IXW'(req_tdata[OFS_INDEX +: INDEX_W]);
   assign top_ext = IXW'(count_ff - 1'b1);
   assign idx_sel = (idx_ext > top_ext) ? top_ext : idx_ext;

   qsc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_word),
      .rd_addr (idx_sel[AW-1:0]),
      .rd_data (rd_word)
   );

   // Unpack the read quad and apply the corner swap.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         qx[j] = rd_word[j*CW +: CW];
         qy[j] = rd_word[(4+j)*CW +: CW];
      end
      sx0 = qx[0];
      sy0 = qy[0];
      sx1 = qx[1];
      sy1 = qy[1];
      sx2 = qx[2];
      sy2 = qy[2];
      sx3 = qx[3];
      sy3 = qy[3];
      if (pair_ff == PAIR_SWAP_P1) begin
         sx1 = qx[3];
         sy1 = qy[3];
         sx3 = qx[1];
         sy3 = qy[1];
      end else if (pair_ff == PAIR_SWAP_P2) begin
         sx2 = qx[3];
         sy2 = qy[3];
         sx3 = qx[2];
         sy3 = qy[2];
      end
   end

   assign sum_x = (CW+2)'(qx[0]) + (CW+2)'(qx[1]) + (CW+2)'(qx[2]) + (CW+2)'(qx[3]);
   assign sum_y = (CW+2)'(qy[0]) + (CW+2)'(qy[1]) + (CW+2)'(qy[2]) + (CW+2)'(qy[3]);

   // Operand selection for the serial multiplier.
   always_comb begin
      unique case (step_ff)
         STEP_AD: begin
            mul_a = EW'(a_ff);
            mul_b = d_ff;
         end
         STEP_CB: begin
            mul_a = EW'(c_ff);
            mul_b = b_ff;
         end
         STEP_DE: begin
            mul_a = EW'(d_ff);
            mul_b = e_ff;
         end
         STEP_CF: begin
            mul_a = EW'(c_ff);
            mul_b = f_ff;
         end
         STEP_NUMA: begin
            mul_a = num_ff;
            mul_b = a_ff;
         end
         STEP_NUMB: begin
            mul_a = num_ff;
            mul_b = b_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   qsc_mul #(
      .A_W (EW),
      .B_W (DW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_prod)
   );

   qsc_div #(
      .NUM_W (NW),
      .DEN_W (EW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_prod),
      .divisor  (den_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Crossing coordinate: the corner in the P3 place after the swap, plus the quotient.
   assign cross_sum = RW'(div_quot) +
                      RW'({1'b0, ((step_ff == STEP_NUMA) ? x3_ff : y3_ff)});

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (mode == MODE_QUERY && !stack_empty) ? ST_LOAD : ST_OUT;
            end
         end
         ST_LOAD: state_in = ST_MUL;
         ST_MUL: begin
            if (mul_done) begin
               if (step_ff == STEP_CF && den_ff == '0) begin
                  state_in = ST_OUT;
               end else if (step_ff == STEP_NUMA || step_ff == STEP_NUMB) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = (step_ff == STEP_NUMA) ? ST_MUL : ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
      mul_start  = (state_ff == ST_MUL) && !mul_busy && !mul_done;
      div_start  = (state_ff == ST_DIV) && !div_busy && !div_done;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            unique case (mode)
               MODE_PUSH:  count_ff <= stack_full ? count_ff : count_ff + 1'b1;
               MODE_POP:   count_ff <= stack_empty ? count_ff : count_ff - 1'b1;
               MODE_CLEAR: count_ff <= '0;
               MODE_QUERY: count_ff <= count_ff;
               default:    count_ff <= count_ff;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request decode, operand capture and result collection.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         step_ff    <= STEP_AD;
         pair_ff    <= req_tdata[OFS_PAIR +: 2];
         res_cx_ff  <= '0;
         res_cy_ff  <= '0;
         res_kx_ff  <= '0;
         res_ky_ff  <= '0;
         res_par_ff <= 1'b0;
         unique case (mode)
            MODE_PUSH:  res_status_ff <= stack_full ? STATUS_FULL : STATUS_OK;
            MODE_POP:   res_status_ff <= stack_empty ? STATUS_EMPTY : STATUS_OK;
            MODE_CLEAR: res_status_ff <= STATUS_OK;
            MODE_QUERY: res_status_ff <= stack_empty ? STATUS_EMPTY : STATUS_OK;
            default:    res_status_ff <= STATUS_OK;
         endcase
      end
      if (state_ff == ST_LOAD) begin
         a_ff      <= $signed({1'b0, sx0}) - $signed({1'b0, sx3});
         b_ff      <= $signed({1'b0, sy0}) - $signed({1'b0, sy3});
         c_ff      <= $signed({1'b0, sx1}) - $signed({1'b0, sx2});
         d_ff      <= $signed({1'b0, sy1}) - $signed({1'b0, sy2});
         e_ff      <= $signed({1'b0, sx2}) - $signed({1'b0, sx3});
         f_ff      <= $signed({1'b0, sy3}) - $signed({1'b0, sy2});
         x3_ff     <= sx3;
         y3_ff     <= sy3;
         res_cx_ff <= CENTRE_W'(sum_x >> 2);
         res_cy_ff <= CENTRE_W'(sum_y >> 2);
      end
      if (state_ff == ST_MUL && mul_done) begin
         unique case (step_ff)
            STEP_AD: t0_ff  <= mul_prod;
            STEP_CB: den_ff <= EW'(t0_ff - mul_prod);
            STEP_DE: t0_ff  <= mul_prod;
            STEP_CF: begin
               num_ff <= EW'(t0_ff + mul_prod);
               if (den_ff == '0) begin
                  res_par_ff <= 1'b1;
                  res_kx_ff  <= '1;
                  res_ky_ff  <= '1;
               end
            end
            default: t0_ff <= t0_ff;
         endcase
         if (step_ff == STEP_AD || step_ff == STEP_CB ||
             step_ff == STEP_DE || step_ff == STEP_CF) begin
            step_ff <= step_ff + 1'b1;
         end
      end
      if (state_ff == ST_DIV && div_done) begin
         if (step_ff == STEP_NUMA) begin
            res_kx_ff <= cross_sum[CROSS_W-1:0];
            step_ff   <= STEP_NUMB;
         end else begin
            res_ky_ff <= cross_sum[CROSS_W-1:0];
         end
      end
      if (rsp_load) begin
         rsp_data_ff <= {res_par_ff, res_ky_ff, res_kx_ff, res_cy_ff, res_cx_ff,
                         COUNT_W'(count_ff)};
         rsp_user_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[rtl/core/qsc_checker.sv]
`include "quad_stack_with_centre_and_crossing_defines.svh"
// Port-level checks on the response channel of the quadrilateral stack.
// Depends on qsc_pkg and the assertion macros; bound to the top level below.
module qsc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic [qsc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                     rsp_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready
);
   import qsc_pkg::*;

   // A stalled response holds its contents.
   `QSC_CHECK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // Parallel lines report minus one for both crossing coordinates.
   `QSC_CHECK(a_parallel_marks, clock, reset, rsp_tvalid && rsp_tdata[111], (rsp_tdata[110:31] == '1) && (rsp_tuser == STATUS_OK), "parallel response without -1 crossing")

   // An empty stack leaves count and all query fields at zero.
   `QSC_CHECK(a_empty_zero, clock, reset, rsp_tvalid && (rsp_tuser == STATUS_EMPTY), rsp_tdata == '0, "empty-stack response carries data")

   // A dropped push reports a nonzero count and all other fields at zero.
   `QSC_CHECK(a_full_fields, clock, reset, rsp_tvalid && (rsp_tuser == STATUS_FULL), (rsp_tdata[111:7] == '0) && (rsp_tdata[6:0] != '0), "dropped push with bad fields")

endmodule

bind quad_stack_with_centre_and_crossing qsc_checker u_qsc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
